>>> src/qau_pkg.sv
// Package for the quaternion arithmetic unit: fixed-point widths, opcodes,
// shared types and the rounding and saturation helpers.
// No dependencies.
package qau_pkg;

   // Fixed-point format
   localparam int DW = 18;
   localparam int FB = 14;

   // Derived widths
   localparam int PR_W     = 2 * DW - FB + 1;    // rounded product
   localparam int ACC_W    = PR_W + 3;           // sum of up to four terms
   localparam int SUM_W    = 2 * DW + 1;         // sum of four exact squares
   localparam int SQ_STEPS = (SUM_W + 1) / 2;    // square root steps
   localparam int SQ_NW    = 2 * SQ_STEPS;       // square root work width
   localparam int ROOT_W   = SQ_STEPS;           // integer root width
   localparam int DIV_STEPS = FB + 1;            // quotient bits
   localparam int NUM_W    = DW + FB;            // dividend width

   // Stream widths
   localparam int OP_W        = 3;
   localparam int ROW_W       = 2;
   localparam int REQ_TDATA_W = ((8 * DW + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((4 * DW + 7) / 8) * 8;
   localparam int RSP_TUSER_W = ROW_W + 1;

   // Opcodes
   localparam logic [OP_W-1:0] OP_MUL   = 3'd0;
   localparam logic [OP_W-1:0] OP_ROT   = 3'd1;
   localparam logic [OP_W-1:0] OP_ADD   = 3'd2;
   localparam logic [OP_W-1:0] OP_SCALE = 3'd3;
   localparam logic [OP_W-1:0] OP_MAT   = 3'd4;
   localparam logic [OP_W-1:0] OP_NORM  = 3'd5;

   // Matrix row numbers
   localparam logic [ROW_W-1:0] ROW_FIRST = 2'd0;
   localparam logic [ROW_W-1:0] ROW_MID   = 2'd1;
   localparam logic [ROW_W-1:0] ROW_LAST  = 2'd2;

   typedef logic signed [DW-1:0]     data_type;
   typedef logic signed [2*DW-1:0]   prod_type;
   typedef logic signed [PR_W-1:0]   rprod_type;
   typedef logic signed [ACC_W-1:0]  acc_type;
   typedef logic [SUM_W-1:0]         sum_type;
   typedef logic [SQ_NW-1:0]         sqw_type;
   typedef logic [ROOT_W-1:0]        root_type;
   typedef logic [NUM_W-1:0]         num_type;
   typedef logic [DIV_STEPS-1:0]     quo_type;

   localparam acc_type ACC_MAX = acc_type'({1'b0, {(DW-1){1'b1}}});
   localparam acc_type ACC_MIN = -ACC_MAX - acc_type'(1);
   localparam acc_type ONE_ACC = acc_type'(1) << FB;

   typedef struct packed {
      logic     flag;
      data_type val;
   } sat_type;

   typedef struct packed {
      data_type w;
      data_type x;
      data_type y;
      data_type z;
      logic     sat;
   } row_type;

   // One transaction as it travels down the pipeline
   typedef struct packed {
      logic [OP_W-1:0] op;
      row_type         row2;
      row_type         row1;
      row_type         row0;
      data_type        aw;
      data_type        ax;
      data_type        ay;
      data_type        az;
      sum_type         sumsq;
   } item_type;

   // Product rounded half up to FB fraction bits
   function automatic rprod_type rnd_q(input prod_type p);
      prod_type s;
      s = p + (prod_type'(1) <<< (FB - 1));
      return rprod_type'(s >>> FB);
   endfunction

   // Doubled product, rounded with one shift less
   function automatic rprod_type rnd_q2(input prod_type p);
      prod_type s;
      s = p + (prod_type'(1) <<< (FB - 2));
      return rprod_type'(s >>> (FB - 1));
   endfunction

   // Clip to the signed DW range
   function automatic sat_type sat_acc(input acc_type v);
      sat_type r;
      if (v > ACC_MAX) begin
         r.flag = 1'b1;
         r.val  = ACC_MAX[DW-1:0];
      end else if (v < ACC_MIN) begin
         r.flag = 1'b1;
         r.val  = ACC_MIN[DW-1:0];
      end else begin
         r.flag = 1'b0;
         r.val  = v[DW-1:0];
      end
      return r;
   endfunction

endpackage

>>> src/quaternion_arithmetic_unit.sv
// Quaternion arithmetic unit, top level: input decode, pipeline stall
// control and the four stage groups. Depends on qau_pkg and all qau_ modules.
//
// Fully pipelined: one transaction is taken every cycle while the pipeline
// does not stall; a result passes 5 product/sum stages, 19 square root
// stages, 1 divider prep stage, 15 divider stages and 1 output register;
// the normalize path through the square root and the divider sets that
// depth, and all other opcodes travel the same path. A matrix transaction
// occupies the output for three rows, one row per beat, and the next one
// waits for its last row to be taken. Opcodes 6 and 7 are taken and
// dropped without a result. The pipeline stalls as a whole only when its
// final stage holds a result the output register cannot take; a stall
// freezes every stage, bubbles included, and holds off new input.
module quaternion_arithmetic_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [qau_pkg::REQ_TDATA_W-1:0]   req_tdata,   // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
   input  logic [qau_pkg::OP_W-1:0]          req_tuser,   // req_type
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [qau_pkg::RSP_TDATA_W-1:0]   rsp_tdata,   // res_w, res_x, res_y, res_z
   output logic [qau_pkg::RSP_TUSER_W-1:0]   rsp_tuser,   // row_index, saturated
   output logic                              rsp_tlast
);

   qau_pkg::data_type  in_a [4];
   qau_pkg::data_type  in_b [4];
   logic               op_known;
   logic               in_vld;
   logic               adv;
   logic               can_take;

   logic               ar_vld, sq_vld, dv_vld;
   qau_pkg::item_type  ar_item, sq_item, dv_item;
   qau_pkg::root_type  sq_root;

   // Unpack the request
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         in_a[i] = req_tdata[i*qau_pkg::DW +: qau_pkg::DW];
         in_b[i] = req_tdata[(i+4)*qau_pkg::DW +: qau_pkg::DW];
      end
      op_known = (req_tuser == qau_pkg::OP_MUL) || (req_tuser == qau_pkg::OP_ROT)
              || (req_tuser == qau_pkg::OP_ADD) || (req_tuser == qau_pkg::OP_SCALE)
              || (req_tuser == qau_pkg::OP_MAT) || (req_tuser == qau_pkg::OP_NORM);
      in_vld   = req_tvalid && op_known;
   end

   // Pipeline moves when its last stage is empty or can drain
   assign adv        = !dv_vld || can_take;
   assign req_tready = adv;

   qau_arith u_arith (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_vld   (in_vld),
      .in_op    (req_tuser),
      .in_a     (in_a),
      .in_b     (in_b),
      .out_vld  (ar_vld),
      .out_item (ar_item)
   );

   qau_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_vld   (ar_vld),
      .in_item  (ar_item),
      .out_vld  (sq_vld),
      .out_item (sq_item),
      .out_root (sq_root)
   );

   qau_ndiv u_ndiv (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_vld   (sq_vld),
      .in_item  (sq_item),
      .in_root  (sq_root),
      .out_vld  (dv_vld),
      .out_item (dv_item)
   );

   qau_out u_out (
      .clock      (clock),
      .reset      (reset),
      .in_vld     (dv_vld),
      .in_item    (dv_item),
      .can_take   (can_take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> src/qau_arith.sv
// Product and sum stages of the quaternion unit: five register stages that
// form every result except normalization. Depends on qau_pkg.
module qau_arith (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_vld,
   input  logic [qau_pkg::OP_W-1:0] in_op,
   input  qau_pkg::data_type  in_a [4],
   input  qau_pkg::data_type  in_b [4],
   output logic               out_vld,
   output qau_pkg::item_type  out_item
);

   // Stage A: raw products
   logic                      vld_a_ff;
   logic [qau_pkg::OP_W-1:0]  op_a_ff;
   qau_pkg::data_type         a_a_ff [4];
   qau_pkg::data_type         b_a_ff [4];
   qau_pkg::prod_type         pab_a_ff [4][4];
   qau_pkg::prod_type         paa_a_ff [4][4];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
      end else if (en) begin
         vld_a_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op_a_ff <= in_op;
         for (int i = 0; i < 4; i++) begin
            a_a_ff[i] <= in_a[i];
            b_a_ff[i] <= in_b[i];
            for (int j = 0; j < 4; j++) begin
               pab_a_ff[i][j] <= qau_pkg::prod_type'(in_a[i]) * qau_pkg::prod_type'(in_b[j]);
               paa_a_ff[i][j] <= qau_pkg::prod_type'(in_a[i]) * qau_pkg::prod_type'(in_a[j]);
            end
         end
      end
   end

   // Stage B: rounding and per-opcode sums
   qau_pkg::acc_type  ma [4][4];
   qau_pkg::acc_type  ta [4][4];
   qau_pkg::acc_type  aa [4];
   qau_pkg::acc_type  res_b_in [3][4];
   qau_pkg::sat_type  t_b_in [3];
   qau_pkg::sum_type  sumsq_b_in;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         aa[i] = qau_pkg::acc_type'(a_a_ff[i]);
         for (int j = 0; j < 4; j++) begin
            ma[i][j] = qau_pkg::acc_type'(qau_pkg::rnd_q(pab_a_ff[i][j]));
            ta[i][j] = qau_pkg::acc_type'(qau_pkg::rnd_q2(paa_a_ff[i][j]));
         end
      end
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 4; c++) begin
            res_b_in[r][c] = '0;
         end
      end
      // rotation intermediate t = a x p
      t_b_in[0] = qau_pkg::sat_acc(ma[2][3] - ma[3][2]);
      t_b_in[1] = qau_pkg::sat_acc(ma[3][1] - ma[1][3]);
      t_b_in[2] = qau_pkg::sat_acc(ma[1][2] - ma[2][1]);
      sumsq_b_in = '0;
      for (int i = 0; i < 4; i++) begin
         sumsq_b_in = sumsq_b_in + qau_pkg::sum_type'($unsigned(paa_a_ff[i][i]));
      end
      case (op_a_ff)
         qau_pkg::OP_MUL: begin
            res_b_in[0][0] = ma[0][0] - ma[1][1] - ma[2][2] - ma[3][3];
            res_b_in[0][1] = ma[1][0] + ma[0][1] + ma[2][3] - ma[3][2];
            res_b_in[0][2] = ma[2][0] + ma[0][2] + ma[3][1] - ma[1][3];
            res_b_in[0][3] = ma[3][0] + ma[0][3] + ma[1][2] - ma[2][1];
         end
         qau_pkg::OP_ADD: begin
            for (int i = 0; i < 4; i++) begin
               res_b_in[0][i] = aa[i] + qau_pkg::acc_type'(b_a_ff[i]);
            end
         end
         qau_pkg::OP_SCALE: begin
            for (int i = 0; i < 4; i++) begin
               res_b_in[0][i] = ma[i][0];
            end
         end
         qau_pkg::OP_MAT: begin
            res_b_in[0][1] = qau_pkg::ONE_ACC - (ta[2][2] + ta[3][3]);
            res_b_in[0][2] = ta[1][2] - ta[3][0];
            res_b_in[0][3] = ta[1][3] + ta[2][0];
            res_b_in[1][1] = ta[1][2] + ta[3][0];
            res_b_in[1][2] = qau_pkg::ONE_ACC - (ta[1][1] + ta[3][3]);
            res_b_in[1][3] = ta[2][3] - ta[1][0];
            res_b_in[2][1] = ta[1][3] - ta[2][0];
            res_b_in[2][2] = ta[2][3] + ta[1][0];
            res_b_in[2][3] = qau_pkg::ONE_ACC - (ta[1][1] + ta[2][2]);
         end
         default: begin
         end
      endcase
   end

   logic                      vld_b_ff;
   logic [qau_pkg::OP_W-1:0]  op_b_ff;
   qau_pkg::data_type         a_b_ff [4];
   qau_pkg::data_type         bv_b_ff [3];
   qau_pkg::acc_type          res_b_ff [3][4];
   qau_pkg::data_type         t_b_ff [3];
   logic                      tflag_b_ff;
   qau_pkg::sum_type          sumsq_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_b_ff <= 1'b0;
      end else if (en) begin
         vld_b_ff <= vld_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op_b_ff    <= op_a_ff;
         sumsq_b_ff <= sumsq_b_in;
         tflag_b_ff <= t_b_in[0].flag | t_b_in[1].flag | t_b_in[2].flag;
         for (int i = 0; i < 4; i++) begin
            a_b_ff[i] <= a_a_ff[i];
         end
         for (int k = 0; k < 3; k++) begin
            bv_b_ff[k] <= b_a_ff[k+1];
            t_b_ff[k]  <= t_b_in[k].val;
            for (int c = 0; c < 4; c++) begin
               res_b_ff[k][c] <= res_b_in[k][c];
            end
         end
      end
   end

   // Stage C: rotation products a * t
   logic                      vld_c_ff;
   logic [qau_pkg::OP_W-1:0]  op_c_ff;
   qau_pkg::data_type         a_c_ff [4];
   qau_pkg::data_type         bv_c_ff [3];
   qau_pkg::acc_type          res_c_ff [3][4];
   qau_pkg::prod_type         prot_c_ff [4][3];
   logic                      tflag_c_ff;
   qau_pkg::sum_type          sumsq_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_c_ff <= 1'b0;
      end else if (en) begin
         vld_c_ff <= vld_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op_c_ff    <= op_b_ff;
         sumsq_c_ff <= sumsq_b_ff;
         tflag_c_ff <= tflag_b_ff;
         for (int i = 0; i < 4; i++) begin
            a_c_ff[i] <= a_b_ff[i];
            for (int k = 0; k < 3; k++) begin
               prot_c_ff[i][k] <= qau_pkg::prod_type'(a_b_ff[i]) * qau_pkg::prod_type'(t_b_ff[k]);
            end
         end
         for (int k = 0; k < 3; k++) begin
            bv_c_ff[k] <= bv_b_ff[k];
            for (int c = 0; c < 4; c++) begin
               res_c_ff[k][c] <= res_b_ff[k][c];
            end
         end
      end
   end

   // Stage D: rotation sums p + 2w t + 2 a x t
   qau_pkg::acc_type  pr [4][3];
   qau_pkg::acc_type  bva [3];
   qau_pkg::acc_type  res_d_in [3][4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         for (int k = 0; k < 3; k++) begin
            pr[i][k] = qau_pkg::acc_type'(qau_pkg::rnd_q2(prot_c_ff[i][k]));
         end
      end
      for (int k = 0; k < 3; k++) begin
         bva[k] = qau_pkg::acc_type'(bv_c_ff[k]);
         for (int c = 0; c < 4; c++) begin
            res_d_in[k][c] = res_c_ff[k][c];
         end
      end
      if (op_c_ff == qau_pkg::OP_ROT) begin
         res_d_in[0][0] = '0;
         res_d_in[0][1] = bva[0] + pr[0][0] + pr[2][2] - pr[3][1];
         res_d_in[0][2] = bva[1] + pr[0][1] + pr[3][0] - pr[1][2];
         res_d_in[0][3] = bva[2] + pr[0][2] + pr[1][1] - pr[2][0];
      end
   end

   logic                      vld_d_ff;
   logic [qau_pkg::OP_W-1:0]  op_d_ff;
   qau_pkg::data_type         a_d_ff [4];
   qau_pkg::acc_type          res_d_ff [3][4];
   logic                      tflag_d_ff;
   qau_pkg::sum_type          sumsq_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_d_ff <= 1'b0;
      end else if (en) begin
         vld_d_ff <= vld_c_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op_d_ff    <= op_c_ff;
         sumsq_d_ff <= sumsq_c_ff;
         tflag_d_ff <= tflag_c_ff;
         for (int i = 0; i < 4; i++) begin
            a_d_ff[i] <= a_c_ff[i];
         end
         for (int k = 0; k < 3; k++) begin
            for (int c = 0; c < 4; c++) begin
               res_d_ff[k][c] <= res_d_in[k][c];
            end
         end
      end
   end

   // Stage E: saturation of every row
   qau_pkg::sat_type   s_e [3][4];
   qau_pkg::row_type   row_e_in [3];
   qau_pkg::item_type  item_e_in;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int c = 0; c < 4; c++) begin
            s_e[k][c] = qau_pkg::sat_acc(res_d_ff[k][c]);
         end
         row_e_in[k].w   = s_e[k][0].val;
         row_e_in[k].x   = s_e[k][1].val;
         row_e_in[k].y   = s_e[k][2].val;
         row_e_in[k].z   = s_e[k][3].val;
         row_e_in[k].sat = s_e[k][0].flag | s_e[k][1].flag | s_e[k][2].flag | s_e[k][3].flag;
      end
      if (op_d_ff == qau_pkg::OP_ROT) begin
         row_e_in[0].sat = row_e_in[0].sat | tflag_d_ff;
      end
      item_e_in.op    = op_d_ff;
      item_e_in.row0  = row_e_in[0];
      item_e_in.row1  = row_e_in[1];
      item_e_in.row2  = row_e_in[2];
      item_e_in.aw    = a_d_ff[0];
      item_e_in.ax    = a_d_ff[1];
      item_e_in.ay    = a_d_ff[2];
      item_e_in.az    = a_d_ff[3];
      item_e_in.sumsq = sumsq_d_ff;
   end

   logic               vld_e_ff;
   qau_pkg::item_type  item_e_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_e_ff <= 1'b0;
      end else if (en) begin
         vld_e_ff <= vld_d_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_e_ff <= item_e_in;
      end
   end

   assign out_vld  = vld_e_ff;
   assign out_item = item_e_ff;

endmodule

>>> src/qau_isqrt.sv
// Pipelined integer square root of the squared length, one result bit per
// stage; the transaction rides along. Depends on qau_pkg.
module qau_isqrt (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_vld,
   input  qau_pkg::item_type  in_item,
   output logic               out_vld,
   output qau_pkg::item_type  out_item,
   output qau_pkg::root_type  out_root
);

   logic               vld_ff  [qau_pkg::SQ_STEPS];
   qau_pkg::item_type  item_ff [qau_pkg::SQ_STEPS];
   qau_pkg::sqw_type   n_ff    [qau_pkg::SQ_STEPS];
   qau_pkg::sqw_type   r_ff    [qau_pkg::SQ_STEPS];

   genvar k;
   generate
      for (k = 0; k < qau_pkg::SQ_STEPS; k++) begin : g_step
         localparam qau_pkg::sqw_type BIT =
            qau_pkg::sqw_type'(1) << (2 * (qau_pkg::SQ_STEPS - 1 - k));
         logic               vld_src;
         qau_pkg::item_type  item_src;
         qau_pkg::sqw_type   n_src, r_src, trial, n_in, r_in;

         if (k == 0) begin : g_first
            assign vld_src  = in_vld;
            assign item_src = in_item;
            assign n_src    = qau_pkg::sqw_type'(in_item.sumsq);
            assign r_src    = '0;
         end else begin : g_next
            assign vld_src  = vld_ff[k-1];
            assign item_src = item_ff[k-1];
            assign n_src    = n_ff[k-1];
            assign r_src    = r_ff[k-1];
         end

         // one digit of the root
         always_comb begin
            trial = r_src + BIT;
            if (n_src >= trial) begin
               n_in = n_src - trial;
               r_in = (r_src >> 1) + BIT;
            end else begin
               n_in = n_src;
               r_in = r_src >> 1;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[k] <= 1'b0;
            end else if (en) begin
               vld_ff[k] <= vld_src;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               item_ff[k] <= item_src;
               n_ff[k]    <= n_in;
               r_ff[k]    <= r_in;
            end
         end
      end
   endgenerate

   assign out_vld  = vld_ff[qau_pkg::SQ_STEPS-1];
   assign out_item = item_ff[qau_pkg::SQ_STEPS-1];
   assign out_root = r_ff[qau_pkg::SQ_STEPS-1][qau_pkg::ROOT_W-1:0];

endmodule

>>> src/qau_ndiv.sv
// Normalization divider: four restoring division lanes, one quotient bit
// per stage, then the normalize result is merged. Depends on qau_pkg.
module qau_ndiv (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_vld,
   input  qau_pkg::item_type  in_item,
   input  qau_pkg::root_type  in_root,
   output logic               out_vld,
   output qau_pkg::item_type  out_item
);

   // Prep stage: magnitudes and rounded dividends
   qau_pkg::data_type  comp [4];
   logic [qau_pkg::DW-1:0] mag [4];
   qau_pkg::num_type   num_p_in [4];

   always_comb begin
      comp[0] = in_item.aw;
      comp[1] = in_item.ax;
      comp[2] = in_item.ay;
      comp[3] = in_item.az;
      for (int i = 0; i < 4; i++) begin
         mag[i]      = comp[i][qau_pkg::DW-1] ? -comp[i] : comp[i];
         num_p_in[i] = (qau_pkg::num_type'(mag[i]) << qau_pkg::FB)
                       + qau_pkg::num_type'(in_root >> 1);
      end
   end

   logic               vld_p_ff;
   qau_pkg::item_type  item_p_ff;
   qau_pkg::root_type  root_p_ff;
   qau_pkg::num_type   num_p_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_p_ff <= 1'b0;
      end else if (en) begin
         vld_p_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_p_ff <= in_item;
         root_p_ff <= in_root;
         for (int i = 0; i < 4; i++) begin
            num_p_ff[i] <= num_p_in[i];
         end
      end
   end

   // Division stages
   logic               vld_ff  [qau_pkg::DIV_STEPS];
   qau_pkg::item_type  item_ff [qau_pkg::DIV_STEPS];
   qau_pkg::root_type  root_ff [qau_pkg::DIV_STEPS];
   qau_pkg::num_type   num_ff  [qau_pkg::DIV_STEPS][4];
   qau_pkg::root_type  rem_ff  [qau_pkg::DIV_STEPS][4];
   qau_pkg::quo_type   q_ff    [qau_pkg::DIV_STEPS][4];

   genvar k;
   generate
      for (k = 0; k < qau_pkg::DIV_STEPS; k++) begin : g_step
         localparam int IDX = qau_pkg::DIV_STEPS - 1 - k;
         logic               vld_src;
         qau_pkg::item_type  item_src;
         qau_pkg::root_type  root_src;
         qau_pkg::num_type   num_src [4];
         qau_pkg::root_type  rem_src [4];
         qau_pkg::quo_type   q_src   [4];
         logic [qau_pkg::ROOT_W:0] sh [4];
         qau_pkg::root_type  rem_in  [4];
         qau_pkg::quo_type   q_in    [4];

         if (k == 0) begin : g_first
            always_comb begin
               vld_src  = vld_p_ff;
               item_src = item_p_ff;
               root_src = root_p_ff;
               for (int i = 0; i < 4; i++) begin
                  num_src[i] = num_p_ff[i];
                  rem_src[i] = qau_pkg::root_type'(num_p_ff[i] >> qau_pkg::DIV_STEPS);
                  q_src[i]   = '0;
               end
            end
         end else begin : g_next
            always_comb begin
               vld_src  = vld_ff[k-1];
               item_src = item_ff[k-1];
               root_src = root_ff[k-1];
               for (int i = 0; i < 4; i++) begin
                  num_src[i] = num_ff[k-1][i];
                  rem_src[i] = rem_ff[k-1][i];
                  q_src[i]   = q_ff[k-1][i];
               end
            end
         end

         // shift in one dividend bit, subtract where it fits
         always_comb begin
            for (int i = 0; i < 4; i++) begin
               sh[i] = {rem_src[i], num_src[i][IDX]};
               if (sh[i] >= {1'b0, root_src}) begin
                  rem_in[i] = qau_pkg::root_type'(sh[i] - {1'b0, root_src});
                  q_in[i]   = q_src[i] | (qau_pkg::quo_type'(1) << IDX);
               end else begin
                  rem_in[i] = qau_pkg::root_type'(sh[i]);
                  q_in[i]   = q_src[i];
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[k] <= 1'b0;
            end else if (en) begin
               vld_ff[k] <= vld_src;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               item_ff[k] <= item_src;
               root_ff[k] <= root_src;
               for (int i = 0; i < 4; i++) begin
                  num_ff[k][i] <= num_src[i];
                  rem_ff[k][i] <= rem_in[i];
                  q_ff[k][i]   <= q_in[i];
               end
            end
         end
      end
   endgenerate

   // Merge: signed quotients, or the identity for a zero length
   localparam int LAST = qau_pkg::DIV_STEPS - 1;
   qau_pkg::item_type  it;
   logic               neg [4];
   qau_pkg::sat_type   s [4];
   qau_pkg::sat_type   s_one;
   qau_pkg::acc_type   qa;

   always_comb begin
      it     = item_ff[LAST];
      neg[0] = it.aw[qau_pkg::DW-1];
      neg[1] = it.ax[qau_pkg::DW-1];
      neg[2] = it.ay[qau_pkg::DW-1];
      neg[3] = it.az[qau_pkg::DW-1];
      for (int i = 0; i < 4; i++) begin
         qa   = qau_pkg::acc_type'(q_ff[LAST][i]);
         s[i] = qau_pkg::sat_acc(neg[i] ? -qa : qa);
      end
      s_one    = qau_pkg::sat_acc(qau_pkg::ONE_ACC);
      out_item = it;
      if (it.op == qau_pkg::OP_NORM) begin
         if (it.sumsq == '0) begin
            out_item.row0.w   = s_one.val;
            out_item.row0.x   = '0;
            out_item.row0.y   = '0;
            out_item.row0.z   = '0;
            out_item.row0.sat = s_one.flag;
         end else begin
            out_item.row0.w   = s[0].val;
            out_item.row0.x   = s[1].val;
            out_item.row0.y   = s[2].val;
            out_item.row0.z   = s[3].val;
            out_item.row0.sat = s[0].flag | s[1].flag | s[2].flag | s[3].flag;
         end
      end
   end

   assign out_vld = vld_ff[LAST];

endmodule

>>> src/qau_out.sv
// Output register of the quaternion unit: holds one transaction and sends
// one result, or three matrix rows in turn. Depends on qau_pkg.
module qau_out (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_vld,
   input  qau_pkg::item_type                 in_item,
   output logic                              can_take,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [qau_pkg::RSP_TDATA_W-1:0]   rsp_tdata,   // res_w, res_x, res_y, res_z
   output logic [qau_pkg::RSP_TUSER_W-1:0]   rsp_tuser,   // row_index, saturated
   output logic                              rsp_tlast
);

   logic                        vld_ff;
   logic [qau_pkg::ROW_W-1:0]   row_ff;
   qau_pkg::item_type           item_ff;
   qau_pkg::row_type            cur_row;
   logic                        cur_last;

   // Row select and last-row detect
   always_comb begin
      case (row_ff)
         qau_pkg::ROW_FIRST: cur_row = item_ff.row0;
         qau_pkg::ROW_MID:   cur_row = item_ff.row1;
         default:            cur_row = item_ff.row2;
      endcase
      cur_last = (item_ff.op != qau_pkg::OP_MAT) || (row_ff == qau_pkg::ROW_LAST);
      can_take = !vld_ff || (rsp_tready && cur_last);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         row_ff <= qau_pkg::ROW_FIRST;
      end else if (can_take) begin
         vld_ff <= in_vld;
         row_ff <= qau_pkg::ROW_FIRST;
      end else if (rsp_tready) begin
         row_ff <= row_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (can_take) begin
         item_ff <= in_item;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tlast  = cur_last;
   assign rsp_tdata  = qau_pkg::RSP_TDATA_W'({cur_row.z, cur_row.y, cur_row.x, cur_row.w});
   assign rsp_tuser  = {cur_row.sat, row_ff};

   // Row counter never passes the last matrix row
   ast_row_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff |-> row_ff != 2'd3)
      else $error("row counter out of range");

   // The third row always closes the transaction
   ast_last_row: assert property (@(posedge clock) disable iff (reset)
      vld_ff && row_ff == qau_pkg::ROW_LAST |-> cur_last)
      else $error("last row not marked last");

   // Later rows only come from a matrix and carry no scalar part
   ast_row_w: assert property (@(posedge clock) disable iff (reset)
      vld_ff && row_ff != qau_pkg::ROW_FIRST |-> item_ff.op == qau_pkg::OP_MAT && cur_row.w == '0)
      else $error("unexpected non-first row");

   // Nothing is presented right after reset
   ast_reset: assert property (@(posedge clock)
      reset |=> !vld_ff)
      else $error("output valid after reset");

endmodule
